/* rtl/rcdq_pkg.sv */
// Package for the reversible circular deque unit.
// Holds sizes, operation and status codes, payload structs and the RAM request struct.
// Depends on nothing; the control, the top level and the testbench import it.
package rcdq_pkg;

  localparam int DEPTH      = 256;
  localparam int DATA_WIDTH = 32;
  localparam int AW         = $clog2(DEPTH);
  localparam int CW         = $clog2(DEPTH + 1);
  localparam int POS_W      = 8;

  localparam logic [2:0] OP_PUSH_END   = 3'd0;
  localparam logic [2:0] OP_PUSH_FRONT = 3'd1;
  localparam logic [2:0] OP_POP_END    = 3'd2;
  localparam logic [2:0] OP_POP_FRONT  = 3'd3;
  localparam logic [2:0] OP_READ       = 3'd4;
  localparam logic [2:0] OP_TOGGLE     = 3'd5;
  localparam logic [2:0] OP_CLEAR      = 3'd6;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;
  localparam logic [1:0] ST_EMPTY = 2'd3;

  typedef struct packed {
    logic [2:0]            operation;
    logic [DATA_WIDTH-1:0] value;
    logic [POS_W-1:0]      position;
  } in_item_t;

  typedef struct packed {
    logic [DATA_WIDTH-1:0] read_value;
    logic [1:0]            status;
    logic [CW-1:0]         length;
    logic                  reversed;
  } out_item_t;

  typedef struct packed {
    logic                  we;
    logic [AW-1:0]         waddr;
    logic [DATA_WIDTH-1:0] wdata;
    logic                  re;
    logic [AW-1:0]         raddr;
  } mem_req_t;

  typedef struct packed {
    logic          rd_hit;
    logic [1:0]    status;
    logic [CW-1:0] length;
    logic          reversed;
  } resp_t;

endpackage

/* rtl/reversible_circular_deque_unit.sv */
// Top level of the reversible circular deque unit: control, ring RAM and result register.
// Depends on rcdq_pkg, rcdq_ctrl and rcdq_ram.
//
//   channel  handshake            payload
//   in       in_valid/in_ready    in_data  (operation, value, position)
//   out      out_valid/out_ready  out_data (read_value, status, length, reversed)
//
// One transaction per cycle unless stalled: each item uses the RAM write or read
// port at most once; its result is presented by a single result register next cycle.
// Reset clears head, count, reverse flag and the result valid flag; RAM contents are
// undefined until pushed. Input stalls only while the result register is full and
// out_ready is low; the registered RAM read data holds during such a stall.
module reversible_circular_deque_unit
  import rcdq_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  mem_req_t              mem_req;
  resp_t                 resp;
  resp_t                 resp_r;
  logic                  out_vld_r;
  logic                  accept;
  logic [DATA_WIDTH-1:0] rdata;

  assign in_ready = !out_vld_r || out_ready;
  assign accept   = in_valid && in_ready;

  rcdq_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .item    (in_data),
    .mem_req (mem_req),
    .resp    (resp)
  );

  rcdq_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (mem_req.we),
    .waddr (mem_req.waddr),
    .wdata (mem_req.wdata),
    .re    (mem_req.re),
    .raddr (mem_req.raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (in_ready) begin
      out_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      resp_r <= resp;
    end
  end

  assign out_valid           = out_vld_r;
  assign out_data.read_value = resp_r.rd_hit ? rdata : '0;
  assign out_data.status     = resp_r.status;
  assign out_data.length     = resp_r.length;
  assign out_data.reversed   = resp_r.reversed;

endmodule

/* rtl/rcdq_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module rcdq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* rtl/rcdq_ctrl.sv */
// Deque control: head pointer, element count and reverse flag.
// Decodes each transaction into a RAM request and a response record.
// Depends on rcdq_pkg.
module rcdq_ctrl
  import rcdq_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     accept,
  input  in_item_t item,
  output mem_req_t mem_req,
  output resp_t    resp
);

  logic [AW-1:0] head_r, head_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          rev_r, rev_nxt;

  logic          full, empty;
  logic          push_back, push_front, pop_back, pop_front;
  logic [CW-1:0] pos_ext;
  logic [CW-1:0] phys;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign pos_ext = CW'(item.position);
  assign phys    = rev_r ? (count_r - CW'(1) - pos_ext) : pos_ext;

  always_comb begin
    head_nxt   = head_r;
    count_nxt  = count_r;
    rev_nxt    = rev_r;
    push_back  = 1'b0;
    push_front = 1'b0;
    pop_back   = 1'b0;
    pop_front  = 1'b0;
    mem_req    = '0;
    resp       = '0;
    mem_req.wdata = item.value;
    mem_req.raddr = head_r + phys[AW-1:0];

    // end and front trade places while reversed
    case (item.operation)
      OP_PUSH_END:   begin push_back  = !rev_r; push_front = rev_r;  end
      OP_PUSH_FRONT: begin push_back  = rev_r;  push_front = !rev_r; end
      OP_POP_END:    begin pop_back   = !rev_r; pop_front  = rev_r;  end
      OP_POP_FRONT:  begin pop_back   = rev_r;  pop_front  = !rev_r; end
      OP_READ: begin
        if (pos_ext >= count_r) begin
          resp.status = ST_RANGE;
        end else begin
          resp.rd_hit = 1'b1;
          mem_req.re  = accept;
        end
      end
      OP_TOGGLE: begin
        rev_nxt = !rev_r;
      end
      OP_CLEAR: begin
        head_nxt  = '0;
        count_nxt = '0;
        rev_nxt   = 1'b0;
      end
      default: begin
      end
    endcase

    if (push_back || push_front) begin
      if (full) begin
        resp.status = ST_FULL;
      end else begin
        mem_req.we = accept;
        count_nxt  = count_r + CW'(1);
        if (push_back) begin
          mem_req.waddr = head_r + count_r[AW-1:0];
        end else begin
          head_nxt      = head_r - AW'(1);
          mem_req.waddr = head_r - AW'(1);
        end
      end
    end

    if (pop_back || pop_front) begin
      if (empty) begin
        resp.status = ST_EMPTY;
      end else begin
        count_nxt = count_r - CW'(1);
        if (pop_front) begin
          head_nxt = head_r + AW'(1);
        end
      end
    end

    resp.length   = count_nxt;
    resp.reversed = rev_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      count_r <= '0;
      rev_r   <= 1'b0;
    end else if (accept) begin
      head_r  <= head_nxt;
      count_r <= count_nxt;
      rev_r   <= rev_nxt;
    end
  end

endmodule

/* test/reversible_circular_deque_unit_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for reversible_circular_deque_unit: directed, fill/drain and random
// operation sequences, checked against an in-bench mirror of the deque. Depends on rcdq_pkg.
module reversible_circular_deque_unit_tb
  import rcdq_pkg::*;
();

  localparam logic [2:0] OP_UNUSED = 3'd7;
  localparam int         TARGET_ITEMS = 1850;
  localparam int         CYCLE_LIMIT  = 1_000_000;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;

  reversible_circular_deque_unit dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  // Mirror of the deque state
  logic [DATA_WIDTH-1:0] mirror_slots [DEPTH];
  logic [AW-1:0]         mirror_head;
  logic [CW-1:0]         mirror_count;
  logic                  mirror_rev;

  out_item_t answers_due [$];
  int        errors;
  int        items_sent;
  int        cycles;
  int        hold_request;
  bit        sender_no_gaps;

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("reversible_circular_deque_unit_tb: done, errors");
      $finish;
    end
  end

  // Apply one transaction to the mirror and return the answer the block must give.
  function automatic out_item_t deque_apply(input in_item_t it);
    out_item_t     r;
    logic          at_front;
    logic [CW-1:0] idx;
    logic [AW-1:0] slot;
    r = '0;
    r.status = ST_OK;
    at_front = (it.operation == OP_PUSH_FRONT || it.operation == OP_POP_FRONT) ^ mirror_rev;
    case (it.operation)
      OP_PUSH_END, OP_PUSH_FRONT: begin
        if (mirror_count == DEPTH) begin
          r.status = ST_FULL;
        end else if (at_front) begin
          mirror_head = mirror_head - 1'b1;
          mirror_slots[mirror_head] = it.value;
          mirror_count = mirror_count + 1'b1;
        end else begin
          slot = mirror_head + mirror_count[AW-1:0];
          mirror_slots[slot] = it.value;
          mirror_count = mirror_count + 1'b1;
        end
      end
      OP_POP_END, OP_POP_FRONT: begin
        if (mirror_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          if (at_front) mirror_head = mirror_head + 1'b1;
          mirror_count = mirror_count - 1'b1;
        end
      end
      OP_READ: begin
        if (it.position >= mirror_count) begin
          r.status = ST_RANGE;
        end else begin
          idx = mirror_rev ? mirror_count - 1'b1 - it.position : CW'(it.position);
          slot = mirror_head + idx[AW-1:0];
          r.read_value = mirror_slots[slot];
        end
      end
      OP_TOGGLE: mirror_rev = ~mirror_rev;
      OP_CLEAR: begin
        mirror_head  = '0;
        mirror_count = '0;
        mirror_rev   = 1'b0;
      end
      default: ;
    endcase
    r.length   = mirror_count;
    r.reversed = mirror_rev;
    return r;
  endfunction

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 2);
    if (r < 96) return $urandom_range(3, 8);
    return $urandom_range(15, 40);
  endfunction

  function automatic logic [POS_W-1:0] pick_position();
    if (mirror_count != 0 && $urandom_range(0, 99) < 85)
      return POS_W'($urandom_range(0, mirror_count - 1));
    return POS_W'($urandom_range(0, 255));
  endfunction

  task automatic send_item(input logic [2:0] op, input logic [DATA_WIDTH-1:0] val,
                           input logic [POS_W-1:0] pos);
    int       gap;
    in_item_t it;
    gap = sender_no_gaps ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    it.operation = op;
    it.value     = val;
    it.position  = pos;
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    answers_due.push_back(deque_apply(it));
    items_sent++;
  endtask

  // Stop offering and hold until every outstanding result is back
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (answers_due.size() != 0);
  endtask

  // Result checker and receiver-side stall generator
  initial begin : receiver
    int mode;
    int mode_left;
    int stall_left;
    int hold_left;
    bit hold_taken;
    out_item_t exp_item;
    mode = 0;
    mode_left = 0;
    stall_left = 0;
    hold_left = 0;
    hold_taken = 1'b0;
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) begin
        if (answers_due.size() == 0) begin
          errors++;
          $error("unexpected result transaction: %p", out_data);
        end else begin
          exp_item = answers_due.pop_front();
          if (out_data.read_value !== exp_item.read_value) begin
            errors++;
            $error("read_value: expected %h, got %h", exp_item.read_value, out_data.read_value);
          end
          if (out_data.status !== exp_item.status) begin
            errors++;
            $error("status: expected %0d, got %0d", exp_item.status, out_data.status);
          end
          if (out_data.length !== exp_item.length) begin
            errors++;
            $error("length: expected %0d, got %0d", exp_item.length, out_data.length);
          end
          if (out_data.reversed !== exp_item.reversed) begin
            errors++;
            $error("reversed: expected %0d, got %0d", exp_item.reversed, out_data.reversed);
          end
        end
      end
      if (mode_left == 0) begin
        mode = $urandom_range(0, 2);
        mode_left = $urandom_range(20, 200);
      end else begin
        mode_left--;
      end
      // take up a long hold once it is asked for
      if (!hold_taken && hold_request > 0) begin
        hold_taken = 1'b1;
        hold_left = hold_request;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (mode != 0 && $urandom_range(0, 99) < (mode == 1 ? 20 : 40)) begin
        stall_left = pick_gap();
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic test_directed();
    send_item(OP_POP_END,   $urandom, 8'd0);
    send_item(OP_POP_FRONT, $urandom, 8'd0);
    send_item(OP_READ,      $urandom, 8'd0);
    send_item(OP_PUSH_END,  32'h0000_0000, 8'hFF);
    send_item(OP_PUSH_END,  32'hFFFF_FFFF, 8'd0);
    send_item(OP_PUSH_FRONT, 32'h8000_0001, 8'd0);
    send_item(OP_READ,      $urandom, 8'd0);
    send_item(OP_READ,      $urandom, 8'd1);
    send_item(OP_READ,      $urandom, 8'd2);
    send_item(OP_READ,      $urandom, 8'd3);
    send_item(OP_READ,      $urandom, 8'hFF);
    send_item(OP_TOGGLE,    $urandom, 8'd0);
    send_item(OP_READ,      $urandom, 8'd0);
    send_item(OP_PUSH_END,  32'h5A5A_A5A5, 8'd0);
    send_item(OP_PUSH_FRONT, 32'h1234_5678, 8'd0);
    send_item(OP_READ,      $urandom, 8'd0);
    send_item(OP_READ,      $urandom, 8'd4);
    send_item(OP_POP_END,   $urandom, 8'd0);
    send_item(OP_POP_FRONT, $urandom, 8'd0);
    send_item(OP_READ,      $urandom, 8'd1);
    send_item(OP_UNUSED,    $urandom, POS_W'($urandom_range(0, 255)));
    send_item(OP_CLEAR,     $urandom, 8'd0);
    send_item(OP_READ,      $urandom, 8'd0);
    send_item(OP_TOGGLE,    $urandom, 8'd0);
    send_item(OP_TOGGLE,    $urandom, 8'd0);
  endtask

  // Fill to capacity under back pressure, probe the full case, then drain to empty
  task automatic test_fill_and_drain();
    send_item(OP_CLEAR, $urandom, 8'd0);
    for (int i = 0; i < DEPTH; i++) begin
      if (i == 20) begin
        hold_request = 60;
        sender_no_gaps = 1'b1;
      end
      if (i == 50) sender_no_gaps = 1'b0;
      send_item($urandom_range(0, 1) ? OP_PUSH_END : OP_PUSH_FRONT, $urandom, 8'd0);
    end
    send_item(OP_PUSH_END,   $urandom, 8'd0);
    send_item(OP_PUSH_FRONT, $urandom, 8'd0);
    send_item(OP_READ,       $urandom, 8'hFF);
    send_item(OP_READ,       $urandom, 8'd0);
    send_item(OP_TOGGLE,     $urandom, 8'd0);
    send_item(OP_PUSH_END,   $urandom, 8'd0);
    send_item(OP_READ,       $urandom, 8'hFF);
    send_item(OP_READ,       $urandom, 8'd0);
    wait_drained();
    while (mirror_count != 0) begin
      if ($urandom_range(0, 7) == 0)
        send_item(OP_READ, $urandom, pick_position());
      else
        send_item($urandom_range(0, 1) ? OP_POP_END : OP_POP_FRONT, $urandom, 8'd0);
    end
    send_item(OP_POP_END,   $urandom, 8'd0);
    send_item(OP_POP_FRONT, $urandom, 8'd0);
    send_item(OP_CLEAR,     $urandom, 8'd0);
  endtask

  // Bursts that grow, shrink or mix the deque, with some noise in between
  task automatic test_random_sequences();
    int kind;
    int len;
    int r;
    logic [2:0] op;
    while (items_sent < TARGET_ITEMS) begin
      r = $urandom_range(0, 99);
      kind = (r < 30) ? 0 : (r < 55) ? 1 : (r < 85) ? 2 : 3;
      len = $urandom_range(8, 40);
      sender_no_gaps = ($urandom_range(0, 3) == 0);
      repeat (len) begin
        r = $urandom_range(0, 99);
        case (kind)
          0: op = (r < 70) ? ($urandom_range(0, 1) ? OP_PUSH_END : OP_PUSH_FRONT) : OP_READ;
          1: op = (r < 70) ? ($urandom_range(0, 1) ? OP_POP_END : OP_POP_FRONT) : OP_READ;
          2: op = (r < 8) ? OP_TOGGLE : 3'($urandom_range(0, 4));
          default: op = (r < 5) ? OP_CLEAR : 3'($urandom_range(0, 7));
        endcase
        send_item(op, $urandom, (kind == 3) ? 8'($urandom_range(0, 255)) : pick_position());
      end
    end
    sender_no_gaps = 1'b0;
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    items_sent = 0;
    hold_request = 0;
    sender_no_gaps = 1'b0;
    mirror_head = '0;
    mirror_count = '0;
    mirror_rev = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_fill_and_drain();
    test_random_sequences();
    wait_drained();
    repeat (8) @(posedge clk);
    if (answers_due.size() != 0)
      $error("%0d results never arrived", answers_due.size());
    if (errors == 0 && answers_due.size() == 0)
      $display("reversible_circular_deque_unit_tb: done, clean");
    else
      $display("reversible_circular_deque_unit_tb: done, errors");
    $finish;
  end

endmodule

/* files.f */
rtl/rcdq_pkg.sv
rtl/rcdq_ram.sv
rtl/rcdq_ctrl.sv
rtl/reversible_circular_deque_unit.sv
test/reversible_circular_deque_unit_tb.sv
